[hw/rtl/lz77te_pkg.sv]
package lz77te_pkg;

    // fixed field widths of the request and result channels
    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 4;
    localparam int LENGTH_W = 8;

    // one result triple as held in the output register
    typedef struct packed {
        logic [OFFSET_W-1:0] match_offset;
        logic [LENGTH_W-1:0] match_length;
        logic [DATA_W-1:0]   next_symbol;
        logic                final_triple;
    } triple_t;

endpackage

[hw/rtl/lz77_triple_encoder_top.sv]
// Streaming LZ77 encoder producing (offset, length, next symbol) triples.
// Input channel: one byte per request on data_byte, with end_of_stream set
// on the final byte; accepted when in_valid is high and in_stall is low.
// Output channel: at most one triple per request on match_offset, match_length,
// next_symbol and final_triple; taken when out_valid is high and out_stall
// is low. A byte that extends a match produces no triple.
// An accepted byte loads the input register; the window compare result for
// it is then loaded into the output register. Throughput is one byte per
// cycle while in_stall stays low; all WINDOW history entries are compared
// against the byte in parallel, and match state updates in that same
// cycle.
// When out_stall holds a pending triple, bytes that only extend the match
// still flow; a byte that would emit waits in the input register and
// in_stall rises until the output register frees up.
// Reset clears the history, fill count, match mask and run length; the
// history is kept across the end of a stream, only the match restarts.
module lz77_triple_encoder_top
    import lz77te_pkg::*;
#(
    parameter int WINDOW    = 8,
    parameter int MAX_MATCH = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DATA_W-1:0]   data_byte,
    input  logic                end_of_stream,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OFFSET_W-1:0] match_offset,
    output logic [LENGTH_W-1:0] match_length,
    output logic [DATA_W-1:0]   next_symbol,
    output logic                final_triple
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int OFF_W  = $clog2(WINDOW + 1);
    localparam int RUN_W  = $clog2(MAX_MATCH + 1);

    // input register
    logic              s1_valid_reg, s1_valid_next;
    logic [DATA_W-1:0] s1_data_reg;
    logic              s1_last_reg;

    // match state
    logic [DATA_W-1:0] history_reg [WINDOW];
    logic [DATA_W-1:0] history_next [WINDOW];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [WINDOW-1:0] alive_reg, alive_next;
    logic [RUN_W-1:0]  run_reg, run_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    triple_t out_reg, out_next;

    logic              in_accept;
    logic              s1_adv;
    logic              out_free;
    logic              emit;
    logic [WINDOW-1:0] cand;
    logic [WINDOW-1:0] match;
    logic [OFF_W-1:0]  low_off;
    logic [OFF_W+OFFSET_W-1:0] off_wide;
    logic [RUN_W+LENGTH_W-1:0] run_wide;

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!emit || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // candidate offsets and parallel compare
    always_comb
    begin
        for (int d = 0; d < WINDOW; d++)
        begin
            if (run_reg == '0)
                cand[d] = (FILL_W'(d) < fill_reg);
            else
                cand[d] = alive_reg[d];
            match[d] = cand[d] && (history_reg[d] == s1_data_reg);
        end
    end

    assign emit = (match == '0) || s1_last_reg || (run_reg >= RUN_W'(MAX_MATCH));

    // nearest surviving offset
    always_comb
    begin
        low_off = '0;
        for (int d = WINDOW - 1; d >= 0; d--)
        begin
            if (alive_reg[d])
                low_off = OFF_W'(d + 1);
        end
    end

    assign off_wide = {{OFFSET_W{1'b0}}, (run_reg == '0) ? {OFF_W{1'b0}} : low_off};
    assign run_wide = {{LENGTH_W{1'b0}}, run_reg};

    // input register next values
    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // match state update
    always_comb
    begin
        history_next = history_reg;
        fill_next    = fill_reg;
        alive_next   = alive_reg;
        run_next     = run_reg;
        if (s1_adv)
        begin
            history_next[0] = s1_data_reg;
            for (int d = 1; d < WINDOW; d++)
                history_next[d] = history_reg[d-1];
            if (fill_reg != FILL_W'(WINDOW))
                fill_next = fill_reg + 1'b1;
            if (emit)
            begin
                alive_next = '0;
                run_next   = '0;
            end
            else
            begin
                alive_next = match;
                run_next   = run_reg + 1'b1;
            end
        end
    end

    // output register next values
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_adv && emit)
        begin
            out_valid_next        = 1'b1;
            out_next.match_offset = off_wide[OFFSET_W-1:0];
            out_next.match_length = run_wide[LENGTH_W-1:0];
            out_next.next_symbol  = s1_data_reg;
            out_next.final_triple = s1_last_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            alive_reg     <= '0;
            run_reg       <= '0;
            for (int d = 0; d < WINDOW; d++)
                history_reg[d] <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            alive_reg     <= alive_next;
            run_reg       <= run_next;
            history_reg   <= history_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= end_of_stream;
        end
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign match_offset = out_reg.match_offset;
    assign match_length = out_reg.match_length;
    assign next_symbol  = out_reg.next_symbol;
    assign final_triple = out_reg.final_triple;

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lz77te_pkg::*;

    localparam int WIN          = 8;
    localparam int MAXM         = 255;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 350;
    localparam int MAX_REPORTS  = 10;

    // one byte request as queued for the driver
    typedef struct {
        logic [DATA_W-1:0] data;
        logic              eos;
    } byte_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [DATA_W-1:0]   data_byte = '0;
    logic                end_of_stream = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OFFSET_W-1:0] match_offset;
    logic [LENGTH_W-1:0] match_length;
    logic [DATA_W-1:0]   next_symbol;
    logic                final_triple;

    byte_req_t pending_reqs[$];
    byte_req_t next_req;
    triple_t   expected_triples[$];

    logic req_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_asks = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   mismatches = 0;
    int   pushed = 0;

    // encoder state as the predictor tracks it
    logic [DATA_W-1:0] win_hist [WIN];
    int                win_fill = 0;
    logic [WIN-1:0]    live_offs = '0;
    int                cur_run = 0;

    lz77_triple_encoder_top #(
        .WINDOW    (WIN),
        .MAX_MATCH (MAXM)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_offset  (match_offset),
        .match_length  (match_length),
        .next_symbol   (next_symbol),
        .final_triple  (final_triple)
    );

    always #5 clk = ~clk;

    // predict the triple, if any, that one accepted byte causes
    task automatic encode_byte(input logic [DATA_W-1:0] b, input logic last);
        logic [WIN-1:0] cand;
        logic [WIN-1:0] hit;
        triple_t        t;
        int             off;
        cand = '0;
        hit  = '0;
        if (cur_run == 0)
        begin
            for (int d = 0; d < win_fill; d++)
                cand[d] = 1'b1;
        end
        else
            cand = live_offs;
        for (int d = 0; d < WIN; d++)
            if (cand[d] && win_hist[d] == b)
                hit[d] = 1'b1;
        if (hit == '0 || last || cur_run >= MAXM)
        begin
            off = 0;
            // nearest surviving offset wins
            if (cur_run != 0)
                for (int d = WIN - 1; d >= 0; d--)
                    if (live_offs[d])
                        off = d + 1;
            t.match_offset = off[OFFSET_W-1:0];
            t.match_length = cur_run[LENGTH_W-1:0];
            t.next_symbol  = b;
            t.final_triple = last;
            expected_triples.insert(expected_triples.size(), t);
            cur_run   = 0;
            live_offs = '0;
        end
        else
        begin
            cur_run   = cur_run + 1;
            live_offs = hit;
        end
        for (int d = WIN - 1; d > 0; d--)
            win_hist[d] = win_hist[d-1];
        win_hist[0] = b;
        if (win_fill < WIN)
            win_fill = win_fill + 1;
    endtask

    // driver: offer queued requests, hold a stalled one
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs[0];
                pending_reqs.delete(0);
                in_valid      <= 1'b1;
                data_byte     <= next_req.data;
                end_of_stream <= next_req.eos;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served <= hold_asks;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: check taken triples, predict from taken bytes
    always @(posedge clk)
    begin
        triple_t got;
        triple_t want;
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.match_offset = match_offset;
                got.match_length = match_length;
                got.next_symbol  = next_symbol;
                got.final_triple = final_triple;
                if (expected_triples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected triple: off=%0d len=%0d sym=%02h fin=%0b",
                                 got.match_offset, got.match_length,
                                 got.next_symbol, got.final_triple);
                end
                else
                begin
                    want = expected_triples[0];
                    expected_triples.delete(0);
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("triple mismatch: expected off=%0d len=%0d sym=%02h fin=%0b",
                                     want.match_offset, want.match_length,
                                     want.next_symbol, want.final_triple);
                            $display("                 got      off=%0d len=%0d sym=%02h fin=%0b",
                                     got.match_offset, got.match_length,
                                     got.next_symbol, got.final_triple);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                encode_byte(data_byte, end_of_stream);
        end
    end

    task automatic push_req(input logic [DATA_W-1:0] b, input logic e);
        byte_req_t r;
        r.data = b;
        r.eos  = e;
        pending_reqs.insert(pending_reqs.size(), r);
        pushed++;
    endtask

    // one short stream: random bytes, small alphabet, or a repeating pattern
    task automatic push_burst();
        int                mode;
        int                len;
        int                per;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] pat [9];
        logic [DATA_W-1:0] b;
        logic              e;
        mode = $urandom_range(9);
        len  = $urandom_range(40, 1);
        per  = $urandom_range(9, 1);
        base = DATA_W'($urandom_range(255));
        for (int k = 0; k < 9; k++)
        begin
            if ($urandom_range(1) == 0)
                pat[k] = base + DATA_W'($urandom_range(2));
            else
                pat[k] = DATA_W'($urandom_range(255));
        end
        for (int k = 0; k < len; k++)
        begin
            if (mode < 2)
                b = DATA_W'($urandom_range(255));
            else if (mode < 5)
                b = base + DATA_W'($urandom_range(2));
            else
            begin
                b = pat[k % per];
                if ($urandom_range(15) == 0)
                    b = DATA_W'($urandom_range(255));
            end
            e = (k == len - 1) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0);
            push_req(b, e);
        end
    endtask

    // a run of one byte long enough to hit the length cap
    task automatic push_run(input int len);
        logic [DATA_W-1:0] b;
        b = DATA_W'($urandom_range(255));
        for (int k = 0; k < len; k++)
            push_req(b, k == len - 1);
    endtask

    task automatic fill_phase(input int count);
        int target;
        target = pushed + count;
        while (pushed < target)
            push_burst();
    endtask

    // wait for the driver to empty its queue and every triple to arrive
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_triples.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int d = 0; d < WIN; d++)
            win_hist[d] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty history, extremes, last byte on a match
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'hFF, 1'b1);
        // fill the window, then match at the oldest entry
        for (int k = 0; k < 8; k++)
            push_req(DATA_W'(8'h11 + k), 1'b0);
        push_req(8'h11, 1'b0);
        push_req(8'h12, 1'b0);
        push_req(8'h20, 1'b0);
        // overlapping copy of a single byte, ended by the last flag
        for (int k = 0; k < 5; k++)
            push_req(8'h5A, 1'b0);
        push_req(8'h33, 1'b1);
        push_req(8'hC3, 1'b1);
        drain();

        // receiver holds off while the sender keeps offering
        hold_asks++;
        fill_phase(60);
        drain();

        // no idling, including a capped match
        fill_phase(PHASE_ITEMS / 2);
        push_run($urandom_range(300, 258));
        fill_phase(PHASE_ITEMS / 2);
        drain();

        // sender mostly idle
        send_idle_pct  = 86;
        recv_stall_pct = 0;
        fill_phase(PHASE_ITEMS);
        drain();

        // receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 86;
        fill_phase(PHASE_ITEMS);
        drain();

        // both idling, another long hold-off and capped match
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        fill_phase(PHASE_ITEMS / 2);
        hold_asks++;
        push_run($urandom_range(300, 258));
        fill_phase(PHASE_ITEMS / 2);
        push_req(DATA_W'($urandom_range(255)), 1'b1);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_triples.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lz77te_pkg.sv
hw/rtl/lz77_triple_encoder_top.sv
test/tb.sv
